/* src/urf_pkg.sv */
// ----------------------------------------------------------------------------
// urf_pkg: shared types and constants of the UART register file
// Beat layouts for both channels, register offsets and bit masks.
// ----------------------------------------------------------------------------
package urf_pkg;

  // Request beat
  typedef struct packed {
    logic        req_type;    // 0 = port read, 1 = port write
    logic [15:0] port;
    logic [7:0]  write_data;
  } in_t;

  // Result beat
  typedef struct packed {
    logic [7:0] read_data;
    logic       tx_valid;
    logic [7:0] tx_char;
    logic       bad_port;
  } out_t;

  // Access kinds
  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // Register offsets from the base port
  localparam logic [2:0] OFF_DATA = 3'd0;  // rx/tx or divisor low
  localparam logic [2:0] OFF_IER  = 3'd1;  // irq enable or divisor high
  localparam logic [2:0] OFF_IIR  = 3'd2;
  localparam logic [2:0] OFF_LCR  = 3'd3;
  localparam logic [2:0] OFF_MCR  = 3'd4;
  localparam logic [2:0] OFF_LSR  = 3'd5;
  localparam logic [2:0] OFF_MSR  = 3'd6;
  localparam logic [2:0] OFF_SCR  = 3'd7;

  localparam int unsigned LCR_DLAB_BIT  = 7;
  localparam logic [7:0]  LSR_BREAK     = 8'h10;
  localparam logic [7:0]  NIBBLE_MASK   = 8'h0f;
  localparam logic [7:0]  LCR_RESET     = 8'h80;
  localparam logic [7:0]  LSR_RESET     = 8'h60;  // both transmitter-empty bits
  localparam logic [15:0] BASE_PORT_RST = 16'd1016;

  // Configuration register addresses
  localparam int unsigned CFG_ADDR_W    = 3;
  localparam logic        CFG_IDX_BASE  = 1'b0;

endpackage

/* src/urf_apb.sv */
// ----------------------------------------------------------------------------
// urf_apb: configuration port
// Holds the base port number; APB-style writes and reads, no wait states.
// ----------------------------------------------------------------------------
module urf_apb (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [urf_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output logic [15:0]                     base_port
);

  logic [15:0] base_port_r;
  logic [15:0] base_port_nxt;
  logic        hit;

  // register index is paddr / 4
  assign hit = (paddr[urf_pkg::CFG_ADDR_W-1] == urf_pkg::CFG_IDX_BASE);

  always_comb begin
    base_port_nxt = base_port_r;
    if (psel && penable && pwrite && hit) begin
      base_port_nxt = pwdata[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_port_r <= urf_pkg::BASE_PORT_RST;
    end else begin
      base_port_r <= base_port_nxt;
    end
  end

  assign prdata    = hit ? {16'd0, base_port_r} : 32'd0;
  assign pready    = 1'b1;
  assign base_port = base_port_r;

endmodule

/* src/urf_regs.sv */
// ----------------------------------------------------------------------------
// urf_regs: 16550 register bank
// Decodes one access against the base port, reads or updates the bank.
// ----------------------------------------------------------------------------
module urf_regs (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          fire,       // access is retired this cycle
  input  logic [15:0]   base_port,
  input  urf_pkg::in_t  req,
  output urf_pkg::out_t res
);

  logic [7:0] lcr_r, lcr_nxt;
  logic [7:0] ier_r, ier_nxt;
  logic [7:0] mcr_r, mcr_nxt;
  logic [7:0] lsr_r, lsr_nxt;
  logic [7:0] msr_r, msr_nxt;
  logic [7:0] dll_r, dll_nxt;
  logic [3:0] dlm_r, dlm_nxt;
  logic [7:0] scr_r, scr_nxt;

  logic [15:0] offset;
  logic [2:0]  off;
  logic        bad;
  logic        dlab;
  logic        is_wr;
  logic [7:0]  d;
  logic [7:0]  rd;
  logic        tx;

  assign offset = req.port - base_port;   // wraps mod 2^16
  assign off    = offset[2:0];
  assign bad    = |offset[15:3];
  assign dlab   = lcr_r[urf_pkg::LCR_DLAB_BIT];
  assign is_wr  = (req.req_type == urf_pkg::REQ_WRITE);
  assign d      = req.write_data;

  always_comb begin
    lcr_nxt = lcr_r;
    ier_nxt = ier_r;
    mcr_nxt = mcr_r;
    lsr_nxt = lsr_r;
    msr_nxt = msr_r;
    dll_nxt = dll_r;
    dlm_nxt = dlm_r;
    scr_nxt = scr_r;
    rd      = 8'd0;
    tx      = 1'b0;
    if (!bad) begin
      if (is_wr) begin
        case (off)
          urf_pkg::OFF_DATA: begin
            if (dlab) dll_nxt = d;
            else      tx      = 1'b1;
          end
          urf_pkg::OFF_IER: begin
            if (dlab) dlm_nxt = d[3:0] & urf_pkg::NIBBLE_MASK[3:0];
            else      ier_nxt = d;
          end
          urf_pkg::OFF_IIR: ;
          urf_pkg::OFF_LCR: lcr_nxt = d;
          urf_pkg::OFF_MCR: mcr_nxt = d;
          urf_pkg::OFF_LSR: lsr_nxt = d;
          urf_pkg::OFF_MSR: msr_nxt = d;
          urf_pkg::OFF_SCR: scr_nxt = d;
          default: ;
        endcase
      end else begin
        case (off)
          urf_pkg::OFF_DATA: begin
            if (dlab) rd      = dll_r;
            else      lsr_nxt = lsr_r & ~urf_pkg::LSR_BREAK;  // rx read drops break
          end
          urf_pkg::OFF_IER: rd = dlab ? {4'd0, dlm_r} : ier_r;
          urf_pkg::OFF_IIR: rd = 8'd0;
          urf_pkg::OFF_LCR: rd = lcr_r;
          urf_pkg::OFF_MCR: rd = mcr_r;
          urf_pkg::OFF_LSR: rd = lsr_r;
          urf_pkg::OFF_MSR: rd = msr_r;
          urf_pkg::OFF_SCR: rd = scr_r;
          default:          rd = 8'd0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcr_r <= urf_pkg::LCR_RESET;
      ier_r <= 8'd0;
      mcr_r <= 8'd0;
      lsr_r <= urf_pkg::LSR_RESET;
      msr_r <= 8'd0;
      dll_r <= 8'd0;
      dlm_r <= 4'd0;
      scr_r <= 8'd0;
    end else if (fire) begin
      lcr_r <= lcr_nxt;
      ier_r <= ier_nxt;
      mcr_r <= mcr_nxt;
      lsr_r <= lsr_nxt;
      msr_r <= msr_nxt;
      dll_r <= dll_nxt;
      dlm_r <= dlm_nxt;
      scr_r <= scr_nxt;
    end
  end

  assign res.read_data = rd;
  assign res.tx_valid  = tx;
  assign res.tx_char   = tx ? d : 8'd0;
  assign res.bad_port  = bad;

endmodule

/* src/uart_register_file_core.sv */
// ----------------------------------------------------------------------------
// uart_register_file_core: 16550-style UART register file
// One port read or write per request beat, one result beat per request.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake                 beat
//  -------  ---------  ------------------------  ---------------------------
//  in_      input      in_valid / in_stall       urf_pkg::in_t  (access)
//  out_     output     out_valid / out_stall     urf_pkg::out_t (result)
//  cfg      input      psel/penable/pwrite/...   base_port at address 0
//
//  Takes one beat per cycle while in_stall is low. Each beat passes through
//  the request register, then the result register, before out_valid
//  rises.
//  The register bank is updated at the same edge the result is captured, so
//  the following access already sees the new state.
//  in_stall rises only when both the request and result registers are full
//  and out_stall is high; the result register then holds until taken.
//  Synchronous active-low reset clears valids and loads the 16550 reset
//  values (LCR 0x80, LSR 0x60, base port 0x3F8).
// ----------------------------------------------------------------------------
module uart_register_file_core (
  input  logic                            clk,
  input  logic                            rst_n,
  // request channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  urf_pkg::in_t                    in_data,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output urf_pkg::out_t                   out_data,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [urf_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  logic          req_vld_r;
  logic          req_vld_nxt;
  urf_pkg::in_t  req_r;
  logic          res_vld_r;
  logic          res_vld_nxt;
  urf_pkg::out_t res_r;
  urf_pkg::out_t res_comb;
  logic          res_free;
  logic          retire;
  logic          accept;
  logic [15:0]   base_port;

  urf_apb u_apb (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .base_port (base_port)
  );

  // result register can take a new beat when empty or being drained
  assign res_free = !res_vld_r || !out_stall;
  assign retire   = req_vld_r && res_free;
  assign in_stall = req_vld_r && !res_free;
  assign accept   = in_valid && !in_stall;

  urf_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (retire),
    .base_port (base_port),
    .req       (req_r),
    .res       (res_comb)
  );

  always_comb begin
    req_vld_nxt = req_vld_r;
    if (accept)      req_vld_nxt = 1'b1;
    else if (retire) req_vld_nxt = 1'b0;
    res_vld_nxt = res_vld_r;
    if (retire)          res_vld_nxt = 1'b1;
    else if (!out_stall) res_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      req_vld_r <= req_vld_nxt;
      res_vld_r <= res_vld_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_data;
    end
    if (retire) begin
      res_r <= res_comb;
    end
  end

  assign out_valid = res_vld_r;
  assign out_data  = res_r;

endmodule
